// ----- rtl/lspq_pkg.sv -----
// shared constants, types and helpers of the led signal pattern queue
package lspq_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);

  // command queue between front and back
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [2:0]  color;
    logic [15:0] on_duration;
    logic [15:0] off_duration;
    logic        blinking;
    logic [7:0]  blink_total;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       led_write;
    logic [2:0] led_color;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  color;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic        blink;
    logic [7:0]  count;
  } pattern_t;

  localparam int unsigned PATTERN_W = $bits(pattern_t);

  typedef struct packed {
    logic        is_tick;
    pattern_t    pattern;
    logic [31:0] now_time;
  } cmd_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

endpackage

// ----- rtl/lspq_intf.sv -----
// valid/ready channel interfaces for input items and results
interface lspq_in_if;
  import lspq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lspq_out_if;
  import lspq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/led_signal_pattern_queue.sv -----
// top level of the led signal pattern queue
// usage:
// - in_i takes enqueue items (store a pattern) and tick items (play the head
//   pattern at the carried time); out_o returns one result per item, in order
// - an item moves on a transfer when valid and ready are both high
// - the front end holds a two-entry command queue, so in_i keeps taking items
//   while the back end works or a result waits on out_o
// - an enqueue or a tick on an empty queue is handled in the idle state, a tick
//   on a non-empty queue goes on to the exec state, set by the registered
//   read of the pattern store
// - sustained throughput: one item per cycle for enqueues while out_o does not
//   stall; a tick that plays a pattern holds off the next command until it is done
// - a full queue drops the enqueue and reports accepted low
// - reset empties the queue and clears the playback state; the pattern store
//   itself is not cleared, its slots are only read once written
// - when out_o stalls, the result register holds, the back end waits and the
//   command queue fills, after which in_i drops ready
module led_signal_pattern_queue (
  input logic        clk_i,
  input logic        rst_ni,
  lspq_in_if.sink    in_i,
  lspq_out_if.source out_o
);
  import lspq_pkg::*;

  // front to back command handoff
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  lspq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // back end plays the head pattern and owns the result register
  lspq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/lspq_ram.sv -----
// generic single write port ram with registered read
module lspq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/lspq_front.sv -----
// front end: accepts items, classifies them and queues commands for the back end
module lspq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  lspq_in_if.sink       in_i,
  output logic          cmd_valid_o,
  output lspq_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);
  import lspq_pkg::*;

  cmd_t                entries_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0] count_q, count_d;
  logic                push, pop;
  cmd_t                cmd_in;

  // classify the incoming item into a command
  always_comb begin
    cmd_in.is_tick          = (in_i.data.operation == OP_TICK);
    cmd_in.pattern.color    = in_i.data.color;
    cmd_in.pattern.on_time  = in_i.data.on_duration;
    cmd_in.pattern.off_time = in_i.data.off_duration;
    cmd_in.pattern.blink    = in_i.data.blinking;
    cmd_in.pattern.count    = in_i.data.blink_total;
    cmd_in.now_time         = in_i.data.now_time;
  end

  assign in_i.ready  = (count_q != CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entries_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + CQ_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + CQ_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CQ_CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- rtl/lspq_back.sv -----
// back end: pattern store, head playback and result register
module lspq_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  lspq_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  lspq_out_if.source     out_o
);
  import lspq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state_q, state_d;
  logic [IDX_W-1:0] read_index_q, read_index_d;
  logic [IDX_W-1:0] write_index_q, write_index_d;
  logic [OCC_W-1:0] occupancy_q, occupancy_d;
  logic             head_active_q, head_active_d;
  logic             phase_on_q, phase_on_d;
  logic [31:0]      phase_start_q, phase_start_d;
  logic [7:0]       blinks_left_q, blinks_left_d;
  logic [31:0]      now_q, now_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;

  logic             ram_we, ram_re;
  logic [PATTERN_W-1:0] ram_rdata;
  pattern_t         head;
  logic             slot_free, has_room, produce;
  out_item_t        res;

  // tick evaluation signals
  logic [31:0] start;
  logic [7:0]  blinks;
  logic        phon;
  logic [31:0] elapsed;
  logic [16:0] total;
  logic        on_gt, off_gt, tot_gt;

  lspq_ram #(
    .WIDTH (PATTERN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (write_index_q),
    .wdata_i (cmd_i.pattern),
    .re_i    (ram_re),
    .raddr_i (read_index_q),
    .rdata_o (ram_rdata)
  );

  assign head      = pattern_t'(ram_rdata);
  assign slot_free = !out_valid_q || out_o.ready;
  assign has_room  = (occupancy_q < OCC_W'(QUEUE_DEPTH));

  assign start   = head_active_q ? phase_start_q : now_q;
  assign blinks  = head_active_q ? blinks_left_q : head.count;
  assign phon    = head_active_q ? phase_on_q : 1'b1;
  assign elapsed = now_q - start;
  assign total   = {1'b0, head.on_time} + {1'b0, head.off_time};
  assign on_gt   = elapsed > {16'd0, head.on_time};
  assign off_gt  = elapsed > {16'd0, head.off_time};
  assign tot_gt  = elapsed > {15'd0, total};

  always_comb begin
    state_d       = state_q;
    read_index_d  = read_index_q;
    write_index_d = write_index_q;
    occupancy_d   = occupancy_q;
    head_active_d = head_active_q;
    phase_on_d    = phase_on_q;
    phase_start_d = phase_start_q;
    blinks_left_d = blinks_left_q;
    now_d         = now_q;
    cmd_ready_o   = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    produce       = 1'b0;
    res           = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_ready_o = 1'b1;
          if (!cmd_i.is_tick) begin
            produce      = 1'b1;
            res.accepted = has_room;
            if (has_room) begin
              ram_we        = 1'b1;
              write_index_d = next_idx(write_index_q);
              occupancy_d   = occupancy_q + OCC_W'(1);
            end
          end else if (occupancy_q == '0) begin
            produce = 1'b1;
          end else begin
            ram_re  = 1'b1;
            now_d   = cmd_i.now_time;
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        // result slot is known to be empty here
        produce       = 1'b1;
        state_d       = S_IDLE;
        res.led_write = 1'b1;
        head_active_d = 1'b1;
        phase_start_d = start;
        blinks_left_d = blinks;
        phase_on_d    = phon;
        if (head.blink) begin
          if (phon) begin
            res.led_color = head.color;
            if (on_gt) begin
              phase_on_d    = 1'b0;
              phase_start_d = now_q;
              blinks_left_d = blinks - 8'd1;
            end
          end else if (off_gt) begin
            phase_on_d    = 1'b1;
            phase_start_d = now_q;
            if (blinks == 8'd0) begin
              head_active_d = 1'b0;
              read_index_d  = next_idx(read_index_q);
              occupancy_d   = occupancy_q - OCC_W'(1);
            end
          end
        end else if (on_gt) begin
          phase_on_d = 1'b0;
          if (tot_gt) begin
            head_active_d = 1'b0;
            read_index_d  = next_idx(read_index_q);
            occupancy_d   = occupancy_q - OCC_W'(1);
          end
        end else begin
          phase_on_d    = 1'b1;
          res.led_color = head.color;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (produce) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
      out_data_d  = out_data_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      read_index_q  <= '0;
      write_index_q <= '0;
      occupancy_q   <= '0;
      head_active_q <= 1'b0;
      phase_on_q    <= 1'b0;
      phase_start_q <= '0;
      blinks_left_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      read_index_q  <= read_index_d;
      write_index_q <= write_index_d;
      occupancy_q   <= occupancy_d;
      head_active_q <= head_active_d;
      phase_on_q    <= phase_on_d;
      phase_start_q <= phase_start_d;
      blinks_left_q <= blinks_left_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- dv/tb_led_signal_pattern_queue.sv -----
// self-checking testbench of the led signal pattern queue: directed table, then random traffic
`timescale 1ns / 1ps

module tb_led_signal_pattern_queue;
  import lspq_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_ITEMS = 1125;
  localparam int unsigned DRAIN_AT     = 600;      // sender pauses here until all results are in
  localparam int unsigned LONG_HOLD    = 90;       // receiver stall, long enough to back up in_i
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned LIMIT_CYCLES = 400_000;

  // one row of the directed table; typed rows carry their result, the rest use the predictor
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lspq_in_if  in_ch ();
  lspq_out_if out_ch ();

  led_signal_pattern_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // single reset at the start of the run
  initial begin
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // shadow of the queue and playback state
  pattern_t    slot_mem [QUEUE_DEPTH];
  int unsigned head_ptr    = 0;
  int unsigned tail_ptr    = 0;
  int unsigned fill_cnt    = 0;
  bit          playing     = 1'b0;
  bit          lit         = 1'b0;
  logic [31:0] phase_t0    = '0;
  logic [7:0]  blinks_todo = '0;

  out_item_t   led_expect_q [$];
  row_t        stim_rows [$];
  int unsigned bad_cnt   = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;

  // head leaves the queue, its led value of this tick still counts
  function automatic void retire_head();
    head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
    fill_cnt--;
    playing = 1'b0;
  endfunction

  // expected result of one accepted item, advancing the shadow state
  function automatic out_item_t predict_led(input in_item_t item);
    out_item_t   res;
    pattern_t    head;
    logic [31:0] since;
    res = '0;
    if (item.operation == OP_ENQUEUE) begin
      // full queue drops the pattern and leaves everything as it was
      if (fill_cnt < QUEUE_DEPTH) begin
        slot_mem[tail_ptr] = '{item.color, item.on_duration, item.off_duration,
                               item.blinking, item.blink_total};
        tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
        fill_cnt++;
        res.accepted = 1'b1;
      end
    end else if (fill_cnt != 0) begin
      head = slot_mem[head_ptr];
      // first tick on a fresh head starts its on phase at this time stamp
      if (!playing) begin
        phase_t0    = item.now_time;
        playing     = 1'b1;
        lit         = 1'b1;
        blinks_todo = head.count;
      end
      since = item.now_time - phase_t0;
      res.led_write = 1'b1;
      if (head.blink) begin
        if (lit) begin
          res.led_color = head.color;
          if (since > {16'd0, head.on_time}) begin
            lit         = 1'b0;
            phase_t0    = item.now_time;
            blinks_todo = blinks_todo - 8'd1;
          end
        end else if (since > {16'd0, head.off_time}) begin
          // end of an off phase, the pattern is done once no blink is left
          lit      = 1'b1;
          phase_t0 = item.now_time;
          if (blinks_todo == 8'd0) retire_head();
        end
      end else if (since > {16'd0, head.on_time}) begin
        // steady pattern past its on time: off, then gone after on plus off
        lit = 1'b0;
        if (since > {16'd0, head.on_time} + {16'd0, head.off_time}) retire_head();
      end else begin
        lit = 1'b1;
        res.led_color = head.color;
      end
    end
    return res;
  endfunction

  task automatic add_row(input logic op, input logic [2:0] color, input logic [15:0] on_d,
                         input logic [15:0] off_d, input logic blink, input logic [7:0] count,
                         input logic [31:0] stamp, input bit typed, input out_item_t res);
    row_t row;
    row.item  = '{op, color, on_d, off_d, blink, count, stamp};
    row.typed = typed;
    row.res   = res;
    stim_rows.push_back(row);
  endtask

  // offer one item after a random gap, or after the queue of results has drained
  task automatic transfer_item(input in_item_t item, input bit wait_idle, input bit typed,
                               input out_item_t res);
    int unsigned gap;
    out_item_t   pred;
    if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0 || wait_idle) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (wait_idle) begin
        do @(posedge clk_i); while (led_expect_q.size() != 0);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    // transfer at this edge: predict and queue the result
    pred = predict_led(item);
    led_expect_q.push_back(typed ? res : pred);
  endtask

  // stimulus: directed table first, then random enqueues and ticks
  initial begin : stimulus
    in_item_t    item;
    logic [31:0] clock_ms;
    int unsigned enq_pct;
    int unsigned pick;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    clock_ms = '0;

    //       op          col   on        off       blk   cnt    time           typed result
    // tick on an empty queue changes nothing
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'hFFFF_FFFF, 1, {1'b0, 1'b0, 3'd0});
    // zero-length steady pattern: shows once, then pops on the next tick
    add_row(OP_ENQUEUE, 3'd7, 16'h0000, 16'h0000, 1'b0, 8'hFF, 32'hFFFF_FFFF, 1, {1'b1, 1'b0, 3'd0});
    add_row(OP_TICK,    3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 32'd100,       1, {1'b0, 1'b1, 3'd7});
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'd101,       1, {1'b0, 1'b1, 3'd0});
    // longest steady pattern across the time stamp wrap, on plus off at 17 bits
    add_row(OP_ENQUEUE, 3'd3, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'hFFFF_FFF0, 1, {1'b0, 1'b1, 3'd3});
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'h0000_FFEF, 0, '0);
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'h0000_FFF0, 0, '0);
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'h0001_FFEF, 0, '0);
    // single blink: on, off, pop at the end of the off phase
    add_row(OP_ENQUEUE, 3'd5, 16'h0001, 16'h0002, 1'b1, 8'h01, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'd10,        0, '0);
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'd12,        0, '0);
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'd14,        0, '0);
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'd15,        0, '0);
    // blink count zero wraps to 256 blinks, played out by the random ticks
    add_row(OP_ENQUEUE, 3'd1, 16'h0000, 16'h0000, 1'b1, 8'h00, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'd20,        0, '0);
    add_row(OP_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 32'd21,        0, '0);
    // fill the rest of the queue, then one more is dropped
    add_row(OP_ENQUEUE, 3'd0, 16'hFFFF, 16'h0000, 1'b0, 8'hFF, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_ENQUEUE, 3'd6, 16'h0000, 16'hFFFF, 1'b1, 8'h02, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_ENQUEUE, 3'd2, 16'h0005, 16'h0005, 1'b0, 8'hAA, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_ENQUEUE, 3'd4, 16'h0001, 16'h0001, 1'b1, 8'h03, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_ENQUEUE, 3'd1, 16'hFFFF, 16'hFFFF, 1'b0, 8'h55, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_ENQUEUE, 3'd3, 16'h0000, 16'h0000, 1'b1, 8'h01, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_ENQUEUE, 3'd5, 16'h0002, 16'h0003, 1'b0, 8'h00, 32'd0,         1, {1'b1, 1'b0, 3'd0});
    add_row(OP_ENQUEUE, 3'd7, 16'h1234, 16'h4321, 1'b1, 8'h80, 32'hA5A5_5A5A, 1, {1'b0, 1'b0, 3'd0});

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (stim_rows[i]) transfer_item(stim_rows[i].item, 1'b0, stim_rows[i].typed,
                                         stim_rows[i].res);

    // random part: mostly short patterns and small time steps so heads actually play out
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      item = $bits(in_item_t)'({$urandom, $urandom, $urandom});
      // fewer enqueues into a full queue, more into an empty one
      enq_pct = (fill_cnt == QUEUE_DEPTH) ? 8 : (fill_cnt == 0) ? 50 : 30;
      if ($urandom_range(0, 99) < enq_pct) begin
        item.operation = OP_ENQUEUE;
        item.blinking  = ($urandom_range(0, 2) == 0);
        if (item.blinking) begin
          item.blink_total  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(5, 20))
                                                            : 8'($urandom_range(1, 4));
          item.on_duration  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 4));
          item.off_duration = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 4));
        end else begin
          item.on_duration  = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 6));
          item.off_duration = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 6));
        end
      end else begin
        // time mostly creeps, sometimes leaps past long phases, rarely jumps anywhere
        item.operation = OP_TICK;
        pick = $urandom_range(0, 99);
        if (pick < 75) clock_ms = clock_ms + 32'($urandom_range(0, 6));
        else if (pick < 95) clock_ms = clock_ms + 32'($urandom_range(0, 70000));
        else clock_ms = $urandom;
        item.now_time = clock_ms;
      end
      transfer_item(item, n == DRAIN_AT, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (led_expect_q.size() != 0) @(posedge clk_i);
    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: random stalls, two long holds that back the block up
  initial begin : result_sink
    int unsigned gap;
    int unsigned seen_cnt;
    out_item_t   want;
    out_item_t   seen;
    seen_cnt = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
      gap = recv_idle ? $urandom_range(0, 15) : 0;
      if (seen_cnt == 300 || seen_cnt == 900) gap = LONG_HOLD;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      seen = out_ch.data;
      seen_cnt++;
      if (led_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, seen);
        bad_cnt++;
      end else begin
        want = led_expect_q.pop_front();
        if (seen.accepted !== want.accepted) begin
          $display("%0t: accepted expected %0b actual %0b", $time, want.accepted,
                   seen.accepted);
          bad_cnt++;
        end
        if (seen.led_write !== want.led_write) begin
          $display("%0t: led_write expected %0b actual %0b", $time, want.led_write,
                   seen.led_write);
          bad_cnt++;
        end
        if (seen.led_color !== want.led_color) begin
          $display("%0t: led_color expected %0d actual %0d", $time, want.led_color,
                   seen.led_color);
          bad_cnt++;
        end
      end
    end
  end

  // hang guard
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
